/* src/unsorted_array_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the unsorted array priority queue
// Implication checks that are clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/upq_pkg.sv */
// ----------------------------------------------------------------------------
// upq_pkg
// Sizes, codes and shared types of the unsorted array priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package upq_pkg;

    localparam int DEPTH    = 8;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [CNT_W-1:0]          count;
        logic                      empty;
    } t_result;

endpackage

`default_nettype wire

/* src/upq_if.sv */
// ----------------------------------------------------------------------------
// upq_in_if / upq_out_if
// Valid/ready channels for commands into the queue and results out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface upq_in_if;
    import upq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value_in;
    logic signed [PRIO_W-1:0]  priority_in;

    modport source (output valid, output command, output value_in, output priority_in,
                    input ready);
    modport sink   (input valid, input command, input value_in, input priority_in,
                    output ready);
endinterface

interface upq_out_if;
    import upq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value_out;
    logic signed [PRIO_W-1:0]  priority_out;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      is_empty;

    modport source (output valid, output status, output value_out, output priority_out,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input value_out, input priority_out,
                    input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

/* src/unsorted_array_priority_queue.sv */
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue
// Bounded priority queue of DEPTH entries held unsorted in one entry memory.
// ----------------------------------------------------------------------------
// Commands arrive on i_cmd and each produces exactly one result on o_rsp.
// Insert appends at the tail, remove and peek return the entry with the
// greatest signed priority (the earliest inserted among equals), and remove
// closes the gap by moving every later entry down one place. One command is
// worked on at a time. An insert, or any command that ends in an error,
// goes straight to its result. The time taken by a scan or a shift is set
// by the single read port of the entry memory, which is read once per entry
// in the scan and once per moved entry. A finished result waits in an
// output register, so the next command is accepted while it is still to be
// taken.
`default_nettype none

module unsorted_array_priority_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upq_in_if.sink    i_cmd,
    upq_out_if.source o_rsp
);
    import upq_pkg::*;

    `include "unsorted_array_priority_queue_assert.svh"

    t_mem_req w_mem_req;
    t_entry   w_rd_data;
    logic     w_res_valid;
    t_result  w_res;
    logic     w_res_ready;

    logic     r_o_valid;
    t_result  r_o_res;

    upq_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    upq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_mem_req   (w_mem_req),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    assign w_res_ready = !r_o_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_o_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_o_res <= w_res;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_res.status;
    assign o_rsp.value_out    = r_o_res.value;
    assign o_rsp.priority_out = r_o_res.prio;
    assign o_rsp.entry_count  = ENTRY_W'(r_o_res.count);
    assign o_rsp.is_empty     = r_o_res.empty;

    `UPQ_ASSERT_IMPL(a_no_accept_with_result, w_res_valid, !i_cmd.ready,
                     "command accepted while a result is pending")
    `UPQ_ASSERT_IMPL(a_full_at_depth, w_res_valid && (w_res.status == STS_FULL),
                     w_res.count == CNT_W'(DEPTH), "full reported below capacity")
    `UPQ_ASSERT_IMPL(a_error_zero_payload, w_res_valid && (w_res.status != STS_OK),
                     (w_res.value == '0) && (w_res.prio == '0), "error result carries data")
    `UPQ_ASSERT_NEXT(a_result_held, w_res_valid && !w_res_ready,
                     w_res_valid && $stable(w_res), "pending result changed before transfer")

endmodule

`default_nettype wire

/* src/upq_mem.sv */
// ----------------------------------------------------------------------------
// upq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_mem (
    input  logic              i_clk,
    input  upq_pkg::t_mem_req i_req,
    output upq_pkg::t_entry   o_rd_data
);
    import upq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/upq_ctrl.sv */
// ----------------------------------------------------------------------------
// upq_ctrl
// Command sequencer: appends on insert, scans the store for the highest
// priority and closes the gap on remove, then presents one result.
// ----------------------------------------------------------------------------
`default_nettype none

module upq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    upq_in_if.sink            i_cmd,
    output upq_pkg::t_mem_req o_mem_req,
    input  upq_pkg::t_entry   i_rd_data,
    output logic              o_res_valid,
    output upq_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import upq_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_dat_idx, n_dat_idx;
    logic [ADDR_W-1:0] r_best_idx, n_best_idx;
    t_entry            r_best, n_best;
    t_status           r_status, n_status;

    logic              w_accept;
    t_cmd              w_cmd;
    logic              w_full;
    logic              w_rd_en;
    logic              w_take;
    logic              w_scan_last;
    logic              w_shift_done;
    logic [ADDR_W-1:0] w_best_idx;
    t_entry            w_best;

    assign w_cmd    = t_cmd'(i_cmd.command);
    assign w_accept = i_cmd.valid && (r_state == S_IDLE);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_rd_en  = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_idx < r_count);

    // The first entry always seeds the running best; later ones replace it
    // only on a strictly greater priority, so the earliest of equals stays.
    assign w_take       = r_pend && ((r_dat_idx == '0) ||
                          ($signed(i_rd_data.prio) > $signed(r_best.prio)));
    assign w_best_idx   = w_take ? r_dat_idx : r_best_idx;
    assign w_best       = w_take ? i_rd_data : r_best;
    assign w_scan_last  = r_pend && (r_dat_idx == ADDR_W'(r_count - CNT_W'(1)));
    assign w_shift_done = !w_rd_en && !r_pend;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (((w_cmd == CMD_REMOVE) || (w_cmd == CMD_PEEK)) && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = (r_cmd == CMD_REMOVE) ? S_SHIFT : S_RESULT;
                end
            end
            S_SHIFT: begin
                if (w_shift_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake, memory requests and the result.
    always_comb begin
        i_cmd.ready       = (r_state == S_IDLE);
        o_res_valid       = (r_state == S_RESULT);
        o_mem_req         = '0;
        o_mem_req.rd_en   = w_rd_en;
        o_mem_req.rd_addr = r_idx[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_mem_req.wr_en         = w_accept && (w_cmd == CMD_INSERT) && !w_full;
                o_mem_req.wr_addr       = r_count[ADDR_W-1:0];
                o_mem_req.wr_data.value = i_cmd.value_in;
                o_mem_req.wr_data.prio  = i_cmd.priority_in;
            end
            S_SHIFT: begin
                // Each entry read from above the removed one drops by one place.
                o_mem_req.wr_en   = r_pend;
                o_mem_req.wr_addr = r_dat_idx - ADDR_W'(1);
                o_mem_req.wr_data = i_rd_data;
            end
            default: begin
            end
        endcase
        o_res.status = r_status;
        o_res.value  = r_best.value;
        o_res.prio   = r_best.prio;
        o_res.count  = r_count;
        o_res.empty  = (r_count == '0);
    end

    // Next values of the working registers.
    always_comb begin
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_dat_idx  = r_dat_idx;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_status   = r_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd      = w_cmd;
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_best_idx = '0;
                    n_best     = '0;
                    n_status   = STS_OK;
                    case (w_cmd)
                        CMD_INSERT: begin
                            if (w_full) begin
                                n_status = STS_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE, CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_pend     = w_rd_en;
                n_dat_idx  = r_idx[ADDR_W-1:0];
                n_best_idx = w_best_idx;
                n_best     = w_best;
                if (w_rd_en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (w_scan_last) begin
                    n_idx  = CNT_W'(w_best_idx) + CNT_W'(1);
                    n_pend = 1'b0;
                end
            end
            S_SHIFT: begin
                n_pend    = w_rd_en;
                n_dat_idx = r_idx[ADDR_W-1:0];
                if (w_rd_en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (w_shift_done) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_dat_idx  <= n_dat_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_status   <= n_status;
    end

endmodule

`default_nettype wire
